@@ hw/rtl/bksu_pkg.sv @@
// Shared constants and types for the B-spline kernel splat update block.
// Used by bspline_kernel_splat_update_core and bksu_kernel_mem; no dependencies.
package bksu_pkg;

    // default geometry, handed to the top-level parameters
    localparam int KERNEL_X_DEF = 15;
    localparam int KERNEL_Y_DEF = 15;
    localparam int KERNEL_Z_DEF = 15;
    localparam int MAX_SIDE_DEF = 1024;

    // fixed field and register widths
    localparam int CENTER_W   = 12;
    localparam int SEL_W      = 2;
    localparam int SIZE_W     = 11;
    localparam int WEIGHT_W   = 16;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_COMP    = 3;
    localparam int SIZE_RST    = 256;
    // Q18.30 product back to Q16.16, round half up
    localparam int ROUND_SHIFT = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_CENTER_Z  = 3'd2,
        CFG_COMP_SEL  = 3'd3,
        CFG_DELTA     = 3'd4,
        CFG_SIZE_X    = 3'd5,
        CFG_SIZE_Y    = 3'd6,
        CFG_SIZE_Z    = 3'd7
    } t_cfg_idx;

    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

@@ hw/rtl/bksu_kernel_mem.sv @@
// Kernel weight store: one write port, one registered read port.
// Depends on bksu_pkg for the weight type and the default geometry.
module bksu_kernel_mem #(
    parameter int DEPTH = bksu_pkg::KERNEL_X_DEF * bksu_pkg::KERNEL_Y_DEF *
                          bksu_pkg::KERNEL_Z_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  bksu_pkg::t_weight i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output bksu_pkg::t_weight o_rd_data
);
    import bksu_pkg::*;

    t_weight r_mem [DEPTH];
    t_weight r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data while the pipeline stage after it is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/bspline_kernel_splat_update_core.sv @@
// B-spline kernel splat update, top level.
// Depends on bksu_pkg and bksu_kernel_mem.
//
// The block takes one transaction per clock. A transaction with action 0 writes the next
// kernel weight into the store (KERNEL_X*KERNEL_Y*KERNEL_Z entries, 3375 by default, one per
// cycle; extra weights are dropped) and gives no result. A transaction with action 1 is one
// field sample in raster order (x fastest, then y, z, then component 0..2); it moves through
// the pipeline stages below into the output register, with weight * delta added and saturated
// when it lies on the selected component inside the kernel window around the control point.
// The path is four stages: window test and store address, store read, 16x32 multiply,
// round, add and saturate. Every stage has its own valid bit, so the input keeps accepting
// while a result waits on i_stall, until all four stages are full. The store
// needs no clearing after reset: weights must be loaded before the samples that read them.
// Write the configuration only while no sample is in flight.
module bspline_kernel_splat_update_core #(
    parameter int KERNEL_X = bksu_pkg::KERNEL_X_DEF,
    parameter int KERNEL_Y = bksu_pkg::KERNEL_Y_DEF,
    parameter int KERNEL_Z = bksu_pkg::KERNEL_Z_DEF,
    parameter int MAX_SIDE = bksu_pkg::MAX_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bksu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bksu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic signed [bksu_pkg::WEIGHT_W-1:0] i_kernel_weight,
    input  logic signed [bksu_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [bksu_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                              o_last_of_field
);
    import bksu_pkg::*;

    localparam int S_X   = (KERNEL_X - 1) / 2;
    localparam int S_Y   = (KERNEL_Y - 1) / 2;
    localparam int S_Z   = (KERNEL_Z - 1) / 2;
    localparam int W_X   = 2 * S_X + 1;
    localparam int W_Y   = 2 * S_Y + 1;
    localparam int DEPTH = KERNEL_X * KERNEL_Y * KERNEL_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LP_W  = $clog2(DEPTH + 1);
    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int CMP_W = (POS_W + 2 > CENTER_W) ? POS_W + 2 : CENTER_W;
    localparam int D_W   = CMP_W + 1;
    localparam int PROD_W = WEIGHT_W + SAMPLE_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SUM_W  = SAMPLE_W + 3;

    localparam logic signed [D_W-1:0]   SX_D = D_W'(S_X);
    localparam logic signed [D_W-1:0]   SY_D = D_W'(S_Y);
    localparam logic signed [D_W-1:0]   SZ_D = D_W'(S_Z);
    localparam logic [AW-1:0]           STRIDE_Y = AW'(W_X);
    localparam logic [AW-1:0]           STRIDE_Z = AW'(W_X * W_Y);
    localparam logic [LP_W-1:0]         DEPTH_LP = LP_W'(DEPTH);
    localparam logic [CMP_W-1:0]        MAX_CMP  = CMP_W'(MAX_SIDE);
    localparam logic [SEL_W-1:0]        LAST_COMP = SEL_W'(NUM_COMP - 1);
    localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // configuration
    logic signed [CENTER_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [SEL_W-1:0]           r_comp_sel;
    t_sample                    r_delta;
    logic [SIZE_W-1:0]          r_size_x, r_size_y, r_size_z;

    // stream state
    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [SEL_W-1:0] r_pos_comp;
    logic [LP_W-1:0]  r_load_ptr;

    // pipeline
    logic          r_v1, r_v2, r_v3, r_v4;
    logic          r_hit1, r_hit2, r_hit3;
    logic          r_last1, r_last2, r_last3, r_last4;
    logic [AW-1:0] r_addr1;
    t_sample       r_sample1, r_sample2, r_sample3, r_sample4;
    logic signed [PROD_W-1:0] r_prod3;
    t_weight       kw;

    logic en1, en2, en3, en4;
    logic acc, acc_stream, acc_load;

    function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CMP_W-1:0] v;
        v = CMP_W'(s);
        if (v == '0) begin
            v = CMP_W'(1);
        end else if (v > MAX_CMP) begin
            v = MAX_CMP;
        end
        return v;
    endfunction

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    assign acc        = i_valid && en1;
    assign acc_stream = acc && i_action;
    assign acc_load   = acc && !i_action;

    // window test and kernel address
    logic signed [D_W-1:0] dx, dy, dz;
    logic [D_W-1:0]        ox, oy, oz;
    logic                  in_win, hit;
    logic [AW-1:0]         addr;

    assign dx = $signed(D_W'(r_pos_x)) - D_W'(r_center_x);
    assign dy = $signed(D_W'(r_pos_y)) - D_W'(r_center_y);
    assign dz = $signed(D_W'(r_pos_z)) - D_W'(r_center_z);
    assign ox = dx + SX_D;
    assign oy = dy + SY_D;
    assign oz = dz + SZ_D;

    assign in_win = (dx >= -SX_D) && (dx <= SX_D) &&
                    (dy >= -SY_D) && (dy <= SY_D) &&
                    (dz >= -SZ_D) && (dz <= SZ_D);
    assign hit  = in_win && (r_pos_comp == r_comp_sel);
    assign addr = hit ? (AW'(oz) * STRIDE_Z + AW'(oy) * STRIDE_Y + AW'(ox)) : '0;

    // raster advance
    logic wrap_x, wrap_y, wrap_z, wrap_all, last;
    logic [POS_W-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic [SEL_W-1:0] n_pos_comp;

    assign wrap_x = (CMP_W'(r_pos_x) + CMP_W'(1)) >= eff_size(r_size_x);
    assign wrap_y = (CMP_W'(r_pos_y) + CMP_W'(1)) >= eff_size(r_size_y);
    assign wrap_z = (CMP_W'(r_pos_z) + CMP_W'(1)) >= eff_size(r_size_z);
    assign wrap_all = wrap_x && wrap_y && wrap_z;
    assign last = wrap_all && (r_pos_comp >= LAST_COMP);

    always_comb begin
        n_pos_x    = wrap_x ? '0 : r_pos_x + POS_W'(1);
        n_pos_y    = r_pos_y;
        n_pos_z    = r_pos_z;
        n_pos_comp = r_pos_comp;
        if (wrap_x) begin
            n_pos_y = wrap_y ? '0 : r_pos_y + POS_W'(1);
        end
        if (wrap_x && wrap_y) begin
            n_pos_z = wrap_z ? '0 : r_pos_z + POS_W'(1);
        end
        if (wrap_all) begin
            n_pos_comp = last ? '0 : r_pos_comp + SEL_W'(1);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_comp_sel <= '0;
            r_delta    <= '0;
            r_size_x   <= SIZE_W'(SIZE_RST);
            r_size_y   <= SIZE_W'(SIZE_RST);
            r_size_z   <= SIZE_W'(SIZE_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_center_x <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Z: r_center_z <= i_cfg_data[CENTER_W-1:0];
                CFG_COMP_SEL: r_comp_sel <= i_cfg_data[SEL_W-1:0];
                CFG_DELTA:    r_delta    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SIZE_X:   r_size_x   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:   r_size_y   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:   r_size_z   <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_pos_z    <= '0;
            r_pos_comp <= '0;
            r_load_ptr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
        end else begin
            if (acc_stream) begin
                r_pos_x    <= n_pos_x;
                r_pos_y    <= n_pos_y;
                r_pos_z    <= n_pos_z;
                r_pos_comp <= n_pos_comp;
            end
            // stop at the store size; later weights are dropped
            if (acc_load && (r_load_ptr < DEPTH_LP)) begin
                r_load_ptr <= r_load_ptr + LP_W'(1);
            end
            if (en1) r_v1 <= acc_stream;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // round, add, saturate
    logic signed [RND_W-1:0] rnd;
    logic signed [SUM_W-1:0] incr, sum;
    t_sample                 sat;

    assign rnd  = RND_W'(r_prod3) + ROUND_BIAS;
    assign incr = SUM_W'(rnd >>> ROUND_SHIFT);
    assign sum  = SUM_W'(r_sample3) + incr;

    always_comb begin
        if (sum > SAT_MAX) begin
            sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hit1    <= hit;
            r_addr1   <= addr;
            r_sample1 <= i_sample_in;
            r_last1   <= last;
        end
        if (en2) begin
            r_hit2    <= r_hit1;
            r_sample2 <= r_sample1;
            r_last2   <= r_last1;
        end
        if (en3) begin
            r_hit3    <= r_hit2;
            r_sample3 <= r_sample2;
            r_last3   <= r_last2;
            r_prod3   <= PROD_W'(kw) * PROD_W'(r_delta);
        end
        if (en4) begin
            r_sample4 <= r_hit3 ? sat : r_sample3;
            r_last4   <= r_last3;
        end
    end

    bksu_kernel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_kmem (
        .i_clk     (i_clk),
        .i_wr_en   (acc_load && (r_load_ptr < DEPTH_LP)),
        .i_wr_addr (r_load_ptr[AW-1:0]),
        .i_wr_data (i_kernel_weight),
        .i_rd_en   (en2),
        .i_rd_addr (r_addr1),
        .o_rd_data (kw)
    );

    assign o_valid         = r_v4;
    assign o_sample_out    = r_sample4;
    assign o_last_of_field = r_last4;

endmodule
